// ===== design/lid_pkg.sv =====
package lid_pkg;

  localparam int CHAR_W = 8;
  localparam int REQ_W  = 13;
  localparam int IDX_W  = 12;
  localparam int DONE_W = 13;
  localparam int TAG_W  = 8;

  localparam logic MODE_REQUEST = 1'b0;
  localparam logic MODE_CHAR    = 1'b1;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TILDE     = 8'h7E;

  typedef struct packed {
    logic              echo_valid;
    logic [CHAR_W-1:0] echo_byte;
    logic              store_valid;
    logic [IDX_W-1:0]  store_index;
    logic [CHAR_W-1:0] store_byte;
    logic              done_res;
    logic [DONE_W-1:0] done_count;
    logic [TAG_W-1:0]  done_tag;
    logic              last;
  } res_t;

  // up to two results produced by one accepted transaction
  typedef struct packed {
    logic [1:0] num;
    res_t       first;
    res_t       second;
  } push_t;

endpackage

// ===== design/lid_item_if.sv =====
interface lid_item_if;
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic [lid_pkg::CHAR_W-1:0] char_code;
  logic [lid_pkg::REQ_W-1:0]  request_count;
  logic [lid_pkg::TAG_W-1:0]  requester_tag;

  modport source (output valid, mode, char_code, request_count, requester_tag,
                  input ready);
  modport sink   (input valid, mode, char_code, request_count, requester_tag,
                  output ready);
endinterface

// ===== design/lid_result_if.sv =====
interface lid_result_if;
  logic                       valid;
  logic                       ready;
  logic                       echo_valid;
  logic [lid_pkg::CHAR_W-1:0] echo_byte;
  logic                       store_valid;
  logic [lid_pkg::IDX_W-1:0]  store_index;
  logic [lid_pkg::CHAR_W-1:0] store_byte;
  logic                       done_res;
  logic [lid_pkg::DONE_W-1:0] done_count;
  logic [lid_pkg::TAG_W-1:0]  done_tag;
  logic                       last;

  modport source (output valid, echo_valid, echo_byte, store_valid, store_index,
                  store_byte, done_res, done_count, done_tag, last,
                  input ready);
  modport sink   (input valid, echo_valid, echo_byte, store_valid, store_index,
                  store_byte, done_res, done_count, done_tag, last,
                  output ready);
endinterface

// ===== design/lid_res_queue.sv =====
module lid_res_queue (
  input  logic            clk,
  input  logic            rst,
  input  lid_pkg::push_t  push,
  output logic            space,
  lid_result_if.source    result
);
  import lid_pkg::*;

  localparam int DEPTH = 3;

  res_t       q      [DEPTH];
  res_t       q_next [DEPTH];
  logic [1:0] occ;
  logic [1:0] occ_next;
  logic [1:0] base;
  logic       pop;

  assign pop          = result.valid && result.ready;
  assign space        = (occ <= 2'd1);
  assign result.valid = (occ != 2'd0);

  always_comb begin
    base = occ - {1'b0, pop};
    for (int i = 0; i < DEPTH; i++) begin
      if (pop && (i < DEPTH - 1)) begin
        q_next[i] = q[i + 1];
      end else begin
        q_next[i] = q[i];
      end
      if ((push.num != 2'd0) && (2'(i) == base)) begin
        q_next[i] = push.first;
      end
      if ((push.num == 2'd2) && (2'(i) == base + 2'd1)) begin
        q_next[i] = push.second;
      end
    end
    occ_next = base + push.num;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 2'd0;
    end else begin
      occ <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      q[i] <= q_next[i];
    end
  end

  assign result.echo_valid  = q[0].echo_valid;
  assign result.echo_byte   = q[0].echo_byte;
  assign result.store_valid = q[0].store_valid;
  assign result.store_index = q[0].store_index;
  assign result.store_byte  = q[0].store_byte;
  assign result.done_res    = q[0].done_res;
  assign result.done_count  = q[0].done_count;
  assign result.done_tag    = q[0].done_tag;
  assign result.last        = q[0].last;

endmodule

// ===== design/cooked_line_input_discipline.sv =====
// Output: the first result of a transaction accepted at edge t into an empty result
//   queue is offered from the cycle after t (result queue head is a register).
// Throughput: one input transaction per cycle while item.ready shows queue space; a
//   printable character that fills the request yields two results, popped in turn.
// Reset (rst, synchronous, active high): no request open, index and tag zero,
//   result queue empty.
module cooked_line_input_discipline #(
  parameter int MAX_REQUEST = 4096
) (
  input  logic        clk,
  input  logic        rst,
  lid_item_if.sink    item,
  lid_result_if.source result
);
  import lid_pkg::*;

  // counters hold 0..MAX_REQUEST
  localparam int CNT_W = $clog2(MAX_REQUEST + 1);
  // compare width for saturating the request count
  localparam int CMP_W = (CNT_W > REQ_W) ? CNT_W : REQ_W;

  // line state
  logic [CNT_W-1:0] remaining;
  logic [CNT_W-1:0] remaining_next;
  logic [CNT_W-1:0] line_index;
  logic [CNT_W-1:0] line_index_next;
  logic [TAG_W-1:0] reader_tag;
  logic [TAG_W-1:0] reader_tag_next;

  logic             accept;
  logic             space;
  push_t            push;

  // decode of the incoming character
  logic             req_open;
  logic             is_print;
  logic             is_erase;
  logic             finish;
  logic [CNT_W-1:0] sat_count;
  logic [CNT_W-1:0] rem_mid;
  logic [CNT_W-1:0] idx_mid;
  res_t             char_res;
  res_t             done_r;

  assign item.ready = space;
  assign accept     = item.valid && item.ready;

  always_comb begin
    // oversized requests clamp to MAX_REQUEST
    if (CMP_W'(item.request_count) > CMP_W'(MAX_REQUEST)) begin
      sat_count = CNT_W'(MAX_REQUEST);
    end else begin
      sat_count = CNT_W'(item.request_count);
    end

    req_open = (remaining != '0);
    is_print = (item.char_code >= CH_SPACE) && (item.char_code <= CH_TILDE);
    // backspace only erases when something is on the line
    is_erase = (item.char_code == CH_BACKSPACE) && (line_index != '0);

    rem_mid = remaining;
    idx_mid = line_index;
    if (is_print) begin
      rem_mid = remaining - CNT_W'(1);
      idx_mid = line_index + CNT_W'(1);
    end else if (is_erase) begin
      rem_mid = remaining + CNT_W'(1);
      idx_mid = line_index - CNT_W'(1);
    end

    // newline or a full line completes the read
    finish = (item.char_code == CH_NEWLINE) || (rem_mid == '0);

    char_res             = '0;
    char_res.echo_valid  = 1'b1;
    char_res.echo_byte   = item.char_code;
    char_res.store_valid = is_print;
    char_res.store_index = is_print ? IDX_W'(line_index) : '0;
    char_res.store_byte  = is_print ? item.char_code : '0;
    char_res.last        = !finish;

    done_r            = '0;
    done_r.echo_valid = 1'b1;
    done_r.echo_byte  = CH_NEWLINE;
    done_r.done_res   = 1'b1;
    done_r.done_count = DONE_W'(idx_mid);
    done_r.done_tag   = reader_tag;
    done_r.last       = 1'b1;

    push        = '0;
    push.first  = done_r;
    push.second = done_r;
    if (accept && (item.mode == MODE_CHAR) && req_open) begin
      if (is_print || is_erase) begin
        push.first = char_res;
        push.num   = finish ? 2'd2 : 2'd1;
      end else if (finish) begin
        push.num = 2'd1;
      end
    end

    remaining_next  = remaining;
    line_index_next = line_index;
    reader_tag_next = reader_tag;
    if (accept) begin
      if (item.mode == MODE_REQUEST) begin
        remaining_next  = sat_count;
        line_index_next = '0;
        reader_tag_next = item.requester_tag;
      end else if (req_open) begin
        remaining_next  = finish ? '0 : rem_mid;
        line_index_next = idx_mid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining  <= '0;
      line_index <= '0;
      reader_tag <= '0;
    end else begin
      remaining  <= remaining_next;
      line_index <= line_index_next;
      reader_tag <= reader_tag_next;
    end
  end

  // result queue: three entries, takes a transaction while one or none is waiting
  lid_res_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .space  (space),
    .result (result)
  );

endmodule

// ===== design/lid_checker.sv =====
module lid_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       res_valid,
  input logic                       res_ready,
  input logic                       echo_valid,
  input logic [lid_pkg::CHAR_W-1:0] echo_byte,
  input logic                       store_valid,
  input logic [lid_pkg::CHAR_W-1:0] store_byte,
  input logic                       done_res,
  input logic                       last
);
  import lid_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(echo_byte) && $stable(last))
    else $error("result changed while stalled");

  a_store_echo: assert property (@(posedge clk) disable iff (rst)
    res_valid && store_valid |-> echo_valid && (echo_byte == store_byte) && !done_res)
    else $error("stored byte not echoed");

  a_done_nl: assert property (@(posedge clk) disable iff (rst)
    res_valid && done_res |-> (echo_byte == CH_NEWLINE) && last)
    else $error("completion without final newline");

  a_first_of_two: assert property (@(posedge clk) disable iff (rst)
    res_valid && !last |-> store_valid)
    else $error("non-final result is not a stored character");

endmodule

bind cooked_line_input_discipline lid_checker u_lid_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .echo_valid  (result.echo_valid),
  .echo_byte   (result.echo_byte),
  .store_valid (result.store_valid),
  .store_byte  (result.store_byte),
  .done_res    (result.done_res),
  .last        (result.last)
);
